// File: rtl/nirdec_pkg.sv
// ----------------------------------------------------------------------------
// nirdec_pkg
// Shared types, constants and helpers for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package nirdec_pkg;

  localparam int DurW       = 15;
  localparam int WordW      = 16;
  localparam int PayloadW   = 2 * WordW;
  localparam int CountW     = 7;
  localparam int BitIdxW    = $clog2(PayloadW);
  localparam int ApbAddrW   = 5;
  localparam int ApbDataW   = 32;

  localparam logic [CountW-1:0] FrameSymbols   = CountW'(34);
  localparam logic [CountW-1:0] PayloadSymbols = CountW'(PayloadW);
  localparam logic [CountW-1:0] CountMax       = {CountW{1'b1}};

  typedef logic [DurW-1:0] dur_t;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_MARGIN       = 3'd0,
    REG_LEADER_MARK  = 3'd1,
    REG_LEADER_SPACE = 3'd2,
    REG_ZERO_MARK    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_MARK     = 3'd5,
    REG_ONE_SPACE    = 3'd6
  } reg_idx_t;

  localparam dur_t MarginRst      = DurW'(300);
  localparam dur_t LeaderMarkRst  = DurW'(9000);
  localparam dur_t LeaderSpaceRst = DurW'(4500);
  localparam dur_t ZeroMarkRst    = DurW'(560);
  localparam dur_t ZeroSpaceRst   = DurW'(560);
  localparam dur_t OneMarkRst     = DurW'(560);
  localparam dur_t OneSpaceRst    = DurW'(1690);

  typedef struct packed {
    dur_t margin;
    dur_t leader_mark;
    dur_t leader_space;
    dur_t zero_mark;
    dur_t zero_space;
    dur_t one_mark;
    dur_t one_space;
  } cfg_t;

  // Which symbol shapes the current symbol fits.
  typedef struct packed {
    logic leader;
    logic zero;
    logic one;
  } match_t;

  // True when value lies strictly inside target +/- margin. A margin larger
  // than the target never matches.
  function automatic logic near_target(dur_t value, dur_t target, dur_t margin);
    logic [DurW:0] lo;
    logic [DurW:0] hi;
    logic [DurW:0] v;
    lo = {1'b0, target} - {1'b0, margin};
    hi = {1'b0, target} + {1'b0, margin};
    v  = {1'b0, value};
    return (margin <= target) && (v > lo) && (v < hi);
  endfunction

endpackage

// File: rtl/nirdec_cfg.sv
// ----------------------------------------------------------------------------
// nirdec_cfg
// APB register file holding the timing targets and the tolerance.
// ----------------------------------------------------------------------------
module nirdec_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nirdec_pkg::ApbAddrW-1:0] paddr,
  input  logic [nirdec_pkg::ApbDataW-1:0] pwdata,
  output logic [nirdec_pkg::ApbDataW-1:0] prdata,
  output logic                            pready,
  output nirdec_pkg::cfg_t                cfg
);
  import nirdec_pkg::*;

  logic     wr_en;
  reg_idx_t idx;
  dur_t     wval;
  dur_t     rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wval   = pwdata[DurW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.margin       <= MarginRst;
      cfg.leader_mark  <= LeaderMarkRst;
      cfg.leader_space <= LeaderSpaceRst;
      cfg.zero_mark    <= ZeroMarkRst;
      cfg.zero_space   <= ZeroSpaceRst;
      cfg.one_mark     <= OneMarkRst;
      cfg.one_space    <= OneSpaceRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_MARGIN:       cfg.margin       <= wval;
        REG_LEADER_MARK:  cfg.leader_mark  <= wval;
        REG_LEADER_SPACE: cfg.leader_space <= wval;
        REG_ZERO_MARK:    cfg.zero_mark    <= wval;
        REG_ZERO_SPACE:   cfg.zero_space   <= wval;
        REG_ONE_MARK:     cfg.one_mark     <= wval;
        REG_ONE_SPACE:    cfg.one_space    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MARGIN:       rval = cfg.margin;
      REG_LEADER_MARK:  rval = cfg.leader_mark;
      REG_LEADER_SPACE: rval = cfg.leader_space;
      REG_ZERO_MARK:    rval = cfg.zero_mark;
      REG_ZERO_SPACE:   rval = cfg.zero_space;
      REG_ONE_MARK:     rval = cfg.one_mark;
      REG_ONE_SPACE:    rval = cfg.one_space;
      default:          rval = '0;
    endcase
  end

  assign prdata = ApbDataW'(rval);

endmodule

// File: rtl/nirdec_match.sv
// ----------------------------------------------------------------------------
// nirdec_match
// Compares one symbol against the leader, zero and one timings.
// ----------------------------------------------------------------------------
module nirdec_match (
  input  nirdec_pkg::cfg_t   cfg,
  input  nirdec_pkg::dur_t   mark_duration,
  input  nirdec_pkg::dur_t   space_duration,
  output nirdec_pkg::match_t hit
);
  import nirdec_pkg::*;

  assign hit.leader = near_target(mark_duration, cfg.leader_mark, cfg.margin) &&
                      near_target(space_duration, cfg.leader_space, cfg.margin);
  assign hit.zero   = near_target(mark_duration, cfg.zero_mark, cfg.margin) &&
                      near_target(space_duration, cfg.zero_space, cfg.margin);
  assign hit.one    = near_target(mark_duration, cfg.one_mark, cfg.margin) &&
                      near_target(space_duration, cfg.one_space, cfg.margin);

endmodule

// File: rtl/nirdec_frame.sv
// ----------------------------------------------------------------------------
// nirdec_frame
// Per-frame state (count, error flag, payload) and the result register.
// ----------------------------------------------------------------------------
module nirdec_frame (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sym_go,
  input  logic                            sym_last,
  input  nirdec_pkg::match_t              hit,
  input  logic                            res_ready,
  output logic                            res_valid,
  output logic                            res_ok,
  output logic [nirdec_pkg::PayloadW-1:0] res_payload
);
  import nirdec_pkg::*;

  logic [CountW-1:0]   symbol_count;
  logic [CountW-1:0]   symbol_count_next;
  logic                frame_bad;
  logic                frame_bad_next;
  logic [PayloadW-1:0] payload_bits;
  logic [PayloadW-1:0] payload_bits_next;
  logic [CountW-1:0]   bit_pos;
  logic                ok_now;

  assign bit_pos = symbol_count - CountW'(1);

  always_comb begin
    frame_bad_next    = frame_bad;
    payload_bits_next = payload_bits;
    if (symbol_count == '0) begin
      if (!hit.leader) begin
        frame_bad_next = 1'b1;
      end
    end else if (symbol_count <= PayloadSymbols) begin
      // A symbol that fits both shapes is taken as a one.
      if (hit.one) begin
        payload_bits_next[bit_pos[BitIdxW-1:0]] = 1'b1;
      end else if (!hit.zero) begin
        frame_bad_next = 1'b1;
      end
    end
    symbol_count_next = (symbol_count == CountMax) ? symbol_count
                                                   : symbol_count + CountW'(1);
    ok_now = (symbol_count_next == FrameSymbols) && !frame_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      frame_bad    <= 1'b0;
      payload_bits <= '0;
    end else if (sym_go) begin
      if (sym_last) begin
        symbol_count <= '0;
        frame_bad    <= 1'b0;
        payload_bits <= '0;
      end else begin
        symbol_count <= symbol_count_next;
        frame_bad    <= frame_bad_next;
        payload_bits <= payload_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sym_go && sym_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_go && sym_last) begin
      res_ok      <= ok_now;
      res_payload <= ok_now ? payload_bits_next : '0;
    end
  end

endmodule

// File: rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Checks NEC infrared pulse symbols and returns address and command per frame.
// ----------------------------------------------------------------------------
// A symbol in the input register is decided as it moves on; a frame's result
// enters the output register as its last symbol moves on, once that register
// is free. Throughput: one symbol per cycle, set by the single input and result
// register, except while a last symbol waits on a full result register.
// Reset (rst, synchronous) clears the frame state and both valid flags and
// loads the timing registers with the standard NEC values.
//
// The input register holds one symbol. The comparators classify it against
// the leader, zero and one shapes, and as it moves on the frame tracker folds
// the outcome into the symbol count, the error flag and the payload.
// Only the last symbol of a frame produces a result; it goes into the output
// register, which can hold a result while further symbols keep flowing. A last
// symbol waits in the input register only if the output register is still full.
module nec_ir_frame_decoder (
  input  logic                            clk,
  input  logic                            rst,
  // Symbol stream in. tdata: [14:0] mark_duration, [29:15] space_duration,
  // [31:30] zero. tlast: last_symbol.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,
  input  logic                            s_tlast,
  // Frame results out. tdata: [15:0] address, [31:16] command.
  // tuser: [0] frame_ok.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,
  output logic                            m_tuser,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nirdec_pkg::ApbAddrW-1:0] paddr,
  input  logic [nirdec_pkg::ApbDataW-1:0] pwdata,
  output logic [nirdec_pkg::ApbDataW-1:0] prdata,
  output logic                            pready
);
  import nirdec_pkg::*;

  cfg_t                cfg;
  match_t              hit;
  logic                sym_valid;
  dur_t                sym_mark;
  dur_t                sym_space;
  logic                sym_last;
  logic                sym_go;
  logic [PayloadW-1:0] res_payload;

  nirdec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A held symbol moves on unless it closes a frame and the result slot is
  // still occupied.
  assign sym_go   = sym_valid && (!sym_last || !m_tvalid || m_tready);
  assign s_tready = !sym_valid || sym_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (s_tready) begin
      sym_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      sym_mark  <= s_tdata[DurW-1:0];
      sym_space <= s_tdata[2*DurW-1:DurW];
      sym_last  <= s_tlast;
    end
  end

  nirdec_match u_match (
    .cfg            (cfg),
    .mark_duration  (sym_mark),
    .space_duration (sym_space),
    .hit            (hit)
  );

  nirdec_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .sym_go      (sym_go),
    .sym_last    (sym_last),
    .hit         (hit),
    .res_ready   (m_tready),
    .res_valid   (m_tvalid),
    .res_ok      (m_tuser),
    .res_payload (res_payload)
  );

  assign m_tdata = res_payload;

endmodule

// File: bench/tb_nec_ir_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder
// Self-checking bench for the NEC infrared frame decoder. Symbol items are
// streamed in with random gaps and the results are taken with random stalls.
// A behavioral copy of the decoder predicts every frame result, and the
// results are checked field by field in order. Timing registers are rewritten
// over the APB port between phases. The settings include the standard NEC
// values, random values and the extremes.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_decoder;
  import nirdec_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 7;
  localparam int CycleLimit   = 400000;
  // The decoder registers each symbol and then its frame's result. Give it some
  // slack before the timing registers change under it.
  localparam int SettleCycles = 6;
  localparam int HoldCycles   = 300;
  localparam int IdlePct      = 21;
  localparam int RandomItems  = 100;
  localparam int RandomFrames = 3;
  localparam int MaxDur       = 32767;
  localparam int FrameLen     = int'(FrameSymbols);
  // This index has no register behind it, so a write to it must be dropped.
  localparam logic [2:0] RegUnused = 3'd7;

  // Where a generated duration lands relative to its match window.
  localparam int InsideAny   = 0;
  localparam int InsideLow   = 1;
  localparam int InsideHigh  = 2;
  localparam int OutsideLow  = 3;
  localparam int OutsideHigh = 4;

  typedef struct packed {
    logic             ok;
    logic [WordW-1:0] address;
    logic [WordW-1:0] command;
  } frame_result_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // s_tdata: [14:0] mark_duration, [29:15] space_duration, [31:30] zero.
  logic [31:0]         s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // m_tdata: [15:0] address, [31:16] command.
  logic [31:0]         m_tdata;
  // m_tuser: [0] frame_ok.
  logic                m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ApbAddrW-1:0] paddr    = '0;
  logic [ApbDataW-1:0] pwdata   = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Behavioral copy of the decoder: its timing registers and frame state.
  cfg_t                timing;
  logic [CountW-1:0]   symbol_count;
  logic                frame_bad;
  logic [PayloadW-1:0] payload;
  frame_result_t       pending_frames[$];
  frame_result_t       wanted;

  bit   gaps_on     = 1'b1;
  bit   stalls_on   = 1'b1;
  logic hold_active = 1'b0;
  event hold_start;

  int mismatch_count = 0;
  int symbols_sent   = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  nec_ir_frame_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Frame prediction
  // ---------------------------------------------------------------------------

  // A duration fits a target when it lies strictly inside target +/- margin.
  // The window is empty whenever the margin exceeds the target.
  function automatic logic fits(dur_t value, dur_t target);
    if (timing.margin > target) return 1'b0;
    return (int'(value) > int'(target) - int'(timing.margin)) &&
           (int'(value) < int'(target) + int'(timing.margin));
  endfunction

  // Folds one accepted symbol into the frame state. The leader is checked
  // first, then 32 data bits; anything past the data bits only counts toward
  // the length. A symbol that fits both bit shapes is read as a one.
  function automatic void track_symbol(dur_t mark, dur_t space, logic last);
    frame_result_t res;
    if (symbol_count == '0) begin
      if (!(fits(mark, timing.leader_mark) && fits(space, timing.leader_space)))
        frame_bad = 1'b1;
    end else if (symbol_count <= PayloadSymbols) begin
      if (fits(mark, timing.one_mark) && fits(space, timing.one_space))
        payload[symbol_count - 7'd1] = 1'b1;
      else if (!(fits(mark, timing.zero_mark) && fits(space, timing.zero_space)))
        frame_bad = 1'b1;
    end
    // The count sticks at its top value, so an overlong frame stays too long.
    if (symbol_count != CountMax) symbol_count++;
    if (last) begin
      res.ok      = (symbol_count == FrameSymbols) && !frame_bad;
      // A failed frame reports zero address and command.
      res.address = res.ok ? payload[WordW-1:0] : '0;
      res.command = res.ok ? payload[PayloadW-1:WordW] : '0;
      pending_frames.push_back(res);
      symbol_count = '0;
      frame_bad    = 1'b0;
      payload      = '0;
    end
  endfunction

  // Picks a duration near a target under the current margin. The edge modes
  // land on the first value inside or outside the window.
  function automatic dur_t pick_dur(dur_t target, int mode);
    int lo;
    int hi;
    int a;
    int b;
    int v;
    lo = int'(target) - int'(timing.margin);
    hi = int'(target) + int'(timing.margin);
    case (mode)
      InsideLow:   v = lo + 1;
      InsideHigh:  v = hi - 1;
      OutsideLow:  v = lo;
      OutsideHigh: v = hi;
      default: begin
        a = (lo + 1 < 0) ? 0 : lo + 1;
        b = (hi - 1 > MaxDur) ? MaxDur : hi - 1;
        // With an empty window any value will do.
        v = (b >= a) ? int'($urandom_range(b, a)) : int'($urandom_range(MaxDur, 0));
      end
    endcase
    if (v < 0) v = 0;
    if (v > MaxDur) v = MaxDur;
    return dur_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Symbol stream driver
  // ---------------------------------------------------------------------------

  // Offers one symbol and returns right after the edge that accepts it.
  // Readiness is sampled on the falling edge so that it is settled.
  task automatic send_symbol(dur_t mark, dur_t space, logic last);
    while (gaps_on && $urandom_range(99, 0) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, space, mark};
    s_tlast  <= last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    track_symbol(mark, space, last);
    symbols_sent++;
  endtask

  // Sends a frame of the given length that carries address and command. The stop
  // symbol and any after it get a random space, since it is never checked.
  task automatic send_frame(logic [WordW-1:0] address, logic [WordW-1:0] command,
                            int length, int corrupt_pct, int mode);
    logic [PayloadW-1:0] bits;
    dur_t                mark;
    dur_t                space;
    bits = {command, address};
    for (int i = 0; i < length; i++) begin
      if (i == 0) begin
        mark  = pick_dur(timing.leader_mark, mode);
        space = pick_dur(timing.leader_space, mode);
      end else if (i <= PayloadW) begin
        mark  = pick_dur(bits[i-1] ? timing.one_mark : timing.zero_mark, mode);
        space = pick_dur(bits[i-1] ? timing.one_space : timing.zero_space, mode);
      end else begin
        mark  = pick_dur(timing.zero_mark, mode);
        space = dur_t'($urandom_range(MaxDur, 0));
      end
      if ($urandom_range(99, 0) < corrupt_pct) begin
        if ($urandom_range(1, 0) != 0) mark = dur_t'($urandom_range(MaxDur, 0));
        else space = dur_t'($urandom_range(MaxDur, 0));
      end
      send_symbol(mark, space, i == length - 1);
    end
  endtask

  task automatic send_noise(int count);
    repeat (count)
      send_symbol(dur_t'($urandom), dur_t'($urandom), $urandom_range(1, 0) != 0);
  endtask

  // Drops the stream valid and waits until every predicted frame came back
  // and the pipeline has had time to drain symbols that give no result.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // One APB write: setup cycle, then access until pready. The bits above the
  // register width are random and must be ignored by the decoder.
  task automatic write_reg(logic [2:0] index, int value);
    logic [ApbDataW-1:0] word;
    word       = $urandom;
    word[14:0] = value[14:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_MARGIN:       timing.margin       = word[14:0];
      REG_LEADER_MARK:  timing.leader_mark  = word[14:0];
      REG_LEADER_SPACE: timing.leader_space = word[14:0];
      REG_ZERO_MARK:    timing.zero_mark    = word[14:0];
      REG_ZERO_SPACE:   timing.zero_space   = word[14:0];
      REG_ONE_MARK:     timing.one_mark     = word[14:0];
      REG_ONE_SPACE:    timing.one_space    = word[14:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(int margin, int leader_mark, int leader_space,
                            int zero_mark, int zero_space, int one_mark,
                            int one_space);
    wait_idle();
    write_reg(REG_MARGIN, margin);
    write_reg(REG_LEADER_MARK, leader_mark);
    write_reg(REG_LEADER_SPACE, leader_space);
    write_reg(REG_ZERO_MARK, zero_mark);
    write_reg(REG_ZERO_SPACE, zero_space);
    write_reg(REG_ONE_MARK, one_mark);
    write_reg(REG_ONE_SPACE, one_space);
    settings_used++;
  endtask

  function automatic int extreme_dur();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return MaxDur;
      default: return int'($urandom_range(MaxDur, 0));
    endcase
  endfunction

  // Standard NEC values, random plausible values, or values at the limits.
  task automatic random_timing();
    int kind;
    int mg;
    kind = $urandom_range(99, 0);
    mg   = $urandom_range(600, 1);
    if (kind < 20) begin
      set_timing(MarginRst, LeaderMarkRst, LeaderSpaceRst, ZeroMarkRst,
                 ZeroSpaceRst, OneMarkRst, OneSpaceRst);
    end else if (kind < 85) begin
      set_timing(mg, $urandom_range(20000, mg), $urandom_range(10000, mg),
                 $urandom_range(2000, mg), $urandom_range(2000, mg),
                 $urandom_range(2000, mg), $urandom_range(6000, mg));
    end else begin
      set_timing(extreme_dur(), extreme_dur(), extreme_dur(), extreme_dur(),
                 extreme_dur(), extreme_dur(), extreme_dur());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stalls, the long hold-off and the checker
  // ---------------------------------------------------------------------------

  // The long hold-off counts its own cycles, apart from the stimulus.
  initial begin
    forever begin
      @(hold_start);
      hold_active = 1'b1;
      repeat (HoldCycles) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_active) begin
      m_tready <= 1'b0;
    end else if (stalls_on) begin
      m_tready <= ($urandom_range(99, 0) >= IdlePct);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Both handshake signals are stable at the falling edge, so what is seen
  // here is exactly what the next rising edge accepts.
  always @(negedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        $display("%0t: result with no frame pending: ok=%0b address=%h command=%h",
                 $time, m_tuser, m_tdata[15:0], m_tdata[31:16]);
        mismatch_count++;
      end else begin
        wanted = pending_frames.pop_front();
        if (m_tuser !== wanted.ok) begin
          $display("%0t: frame_ok expected %0b actual %0b", $time, wanted.ok, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[15:0] !== wanted.address) begin
          $display("%0t: address expected %h actual %h", $time, wanted.address,
                   m_tdata[15:0]);
          mismatch_count++;
        end
        if (m_tdata[31:16] !== wanted.command) begin
          $display("%0t: command expected %h actual %h", $time, wanted.command,
                   m_tdata[31:16]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d frames still pending", cycle_count,
               pending_frames.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timing. Frames sit on the inner and outer edges of every window; the
  // inner-edge ones carry all-zero and all-one address and command. A two-symbol
  // frame then carries the smallest and largest durations.
  task automatic test_standard_frames();
    send_frame(16'h0000, 16'hFFFF, FrameLen, 0, InsideLow);
    send_frame(16'hFFFF, 16'h0000, FrameLen, 0, InsideHigh);
    send_frame(16'hA5C3, 16'h3C5A, FrameLen, 0, OutsideLow);
    send_frame(16'h5A3C, 16'hC3A5, FrameLen, 0, OutsideHigh);
    send_symbol('0, '1, 1'b0);
    send_symbol('1, '0, 1'b1);
    wait_idle();
  endtask

  // Frames one symbol short, one symbol long and a lone leader all fail even
  // with clean timing. A clean frame afterwards shows that the state was cleared.
  task automatic test_frame_length();
    send_frame(16'($urandom), 16'($urandom), FrameLen - 1, 0, InsideAny);
    send_frame(16'($urandom), 16'($urandom), FrameLen + 1, 0, InsideAny);
    send_frame(16'($urandom), 16'($urandom), 1, 0, InsideAny);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    wait_idle();
  endtask

  // A frame long enough to pin the symbol count at its top value, sent with
  // neither side idling. The good frame after it must decode normally.
  task automatic test_long_frame();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_frame(16'($urandom), 16'($urandom), 140, 0, InsideAny);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_timing_registers();
    // The unused index must leave every register alone.
    write_reg(RegUnused, $urandom_range(MaxDur, 0));
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    // Zero and one share one shape, so every data bit reads as a one.
    set_timing(200, 8000, 4000, 700, 700, 700, 700);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    // The margin exceeds the bit targets, so no data symbol can match.
    set_timing(1000, 9000, 4500, 560, 560, 560, 1690);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    // A zero margin leaves every window empty.
    set_timing(0, 9000, 4500, 560, 560, 560, 1690);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    // Largest margin and targets: any nonzero duration matches every shape.
    set_timing(MaxDur, MaxDur, MaxDur, MaxDur, MaxDur, MaxDur, MaxDur);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 10, InsideAny);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, OutsideLow);
    // Zero targets with zero margin never match.
    set_timing(0, 0, 0, 0, 0, 0, 0);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    set_timing(MarginRst, LeaderMarkRst, LeaderSpaceRst, ZeroMarkRst,
               ZeroSpaceRst, OneMarkRst, OneSpaceRst);
  endtask

  // The receiver holds off for a long stretch while single-symbol frames and
  // a full frame keep coming. The result register fills and the input stalls.
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    -> hold_start;
    send_noise(0);
    repeat (6) send_symbol(dur_t'($urandom), dur_t'($urandom), 1'b1);
    send_frame(16'($urandom), 16'($urandom), FrameLen, 0, InsideAny);
    repeat (4) send_symbol(dur_t'($urandom), dur_t'($urandom), 1'b1);
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, some with the wrong
  // length, and short bursts of noise. The timing changes every other round.
  task automatic test_random_frames();
    int first_symbol;
    int first_result;
    int round;
    int pick;
    first_symbol = symbols_sent;
    first_result = results_seen;
    round        = 0;
    while (symbols_sent - first_symbol < RandomItems ||
           results_seen - first_result < RandomFrames) begin
      if (round % 2 == 0) random_timing();
      // One stretch of rounds runs with no idling on either side.
      gaps_on   = !(round >= 2 && round < 4);
      stalls_on = gaps_on;
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        send_frame(16'($urandom), 16'($urandom), FrameLen,
                   ($urandom_range(3, 0) == 0) ? 3 : 0, InsideAny);
      end else if (pick < 85) begin
        send_frame(16'($urandom), 16'($urandom), $urandom_range(40, 1), 0, InsideAny);
      end else begin
        send_noise($urandom_range(6, 1));
      end
      round++;
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    timing.margin       = MarginRst;
    timing.leader_mark  = LeaderMarkRst;
    timing.leader_space = LeaderSpaceRst;
    timing.zero_mark    = ZeroMarkRst;
    timing.zero_space   = ZeroSpaceRst;
    timing.one_mark     = OneMarkRst;
    timing.one_space    = OneSpaceRst;
    symbol_count        = '0;
    frame_bad           = 1'b0;
    payload             = '0;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_standard_frames();
    test_frame_length();
    test_long_frame();
    test_timing_registers();
    test_backpressure();
    test_random_frames();
    wait_idle();

    $display("sent %0d symbols and checked %0d frame results", symbols_sent,
             results_seen);
    $display("timing settings applied: %0d, including edges and extremes",
             settings_used);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: nec_ir_frame_decoder.f
rtl/nirdec_pkg.sv
rtl/nirdec_cfg.sv
rtl/nirdec_match.sv
rtl/nirdec_frame.sv
rtl/nec_ir_frame_decoder.sv
bench/tb_nec_ir_frame_decoder.sv
